>>> hdl/spms_pkg.sv
// Package for the segment partition maximum-sum block.
// Holds field widths, defaults and the request and result structs.
// Used by segment_partition_max_sum_dp; depends on nothing else.
package spms_pkg;

	localparam int VALUE_W   = 16;
	localparam int TOTAL_W   = 48;
	localparam int CFG_W     = 5;
	localparam int MAX_K_DEF = 16;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1);

	typedef struct packed {
		logic [VALUE_W-1:0] item_value;
		logic               start_new;
	} item_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] best_total;
		logic               saturated;
	} result_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [TOTAL_W-1:0] total;
	} entry_t;

endpackage

>>> hdl/segment_partition_max_sum_dp.sv
// Segment partition maximum-sum block: top level and only module.
// Uses spms_pkg for widths, structs and defaults.
// The scan walks lim window entries per accepted request, then FIN registers the result,
// where lim = min(items held for this sequence + 1, max_segment_length (0 read as 1)), at most MAX_K.
// A new request is taken only once the last result is issued; the window memory has one read
// port and the scan reads one entry per cycle through a shared multiply-add.
// Reset: control clears, max_segment_length becomes 1 and the history is empty;
// the window memory is not cleared.
module segment_partition_max_sum_dp #(
	parameter int MAX_K = spms_pkg::MAX_K_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  spms_pkg::item_t             item,
	output logic                        result_valid,
	input  logic                        result_ready,
	output spms_pkg::result_t           result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [spms_pkg::CFG_W-1:0]  cfg_data
);
	import spms_pkg::*;

	localparam int CW  = $clog2(MAX_K + 1);
	localparam int PW  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
	localparam int PRW = VALUE_W + CW;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	localparam logic [PW-1:0] PTR_LAST = PW'(MAX_K - 1);

	function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
		ptr_dec = (p == '0) ? PTR_LAST : p - PW'(1);
	endfunction

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		ptr_inc = (p == PTR_LAST) ? '0 : p + PW'(1);
	endfunction

	logic [1:0]         state_q;
	logic [CFG_W-1:0]   cfg_q;
	logic [CW-1:0]      seen_q;
	logic [CW-1:0]      lim_q;
	logic [CW-1:0]      len_q;
	logic [PW-1:0]      wptr_q;
	logic [PW-1:0]      rp_q;
	logic [VALUE_W-1:0] v_q;
	logic [VALUE_W-1:0] mx_q;
	logic [TOTAL_W-1:0] best_q;
	logic               sat_q;
	entry_t             rd_q;
	entry_t             mem [MAX_K];

	logic               valid_s1;
	logic [PRW-1:0]     prod_s1;
	logic [TOTAL_W-1:0] prev_s1;

	logic [CW-1:0]      k_c;
	logic [CW-1:0]      seen_c;
	logic [CW-1:0]      lim_c;
	logic [PW-1:0]      rd_addr;
	logic [TOTAL_W:0]   sum_c;
	logic [TOTAL_W-1:0] cand_c;
	logic [TOTAL_W-1:0] best_nx;
	logic               sat_nx;
	logic               item_acc;
	logic               out_free;
	logic               finish;

	assign item_ready = (state_q == ST_IDLE);
	assign cfg_ready  = 1'b1;
	assign item_acc   = item_valid && item_ready;
	assign out_free   = !result_valid || result_ready;
	assign finish     = (state_q == ST_FIN) && out_free;

	always_comb begin
		if (32'(cfg_q) > MAX_K) begin
			k_c = CW'(MAX_K);
		end else if (cfg_q == '0) begin
			k_c = CW'(1);
		end else begin
			k_c = CW'(cfg_q);
		end
		seen_c = item.start_new ? '0 : seen_q;
		lim_c  = (seen_c >= k_c) ? k_c : seen_c + CW'(1);
	end

	assign rd_addr = (state_q == ST_IDLE) ? ptr_dec(wptr_q) : ptr_dec(rp_q);

	always_comb begin
		sum_c   = {1'b0, prev_s1} + (TOTAL_W + 1)'(prod_s1);
		cand_c  = sum_c[TOTAL_W] ? '1 : sum_c[TOTAL_W-1:0];
		best_nx = best_q;
		sat_nx  = sat_q;
		if (valid_s1) begin
			if (cand_c > best_q) begin
				best_nx = cand_c;
			end
			if (sum_c[TOTAL_W]) begin
				sat_nx = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		if (finish) begin
			mem[wptr_q] <= '{value: v_q, total: best_nx};
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE || state_q == ST_SCAN) begin
			rp_q <= rd_addr;
		end
		if (item_acc) begin
			v_q    <= item.item_value;
			mx_q   <= item.item_value;
			lim_q  <= lim_c;
			len_q  <= CW'(1);
			best_q <= '0;
			sat_q  <= 1'b0;
		end else begin
			best_q <= best_nx;
			sat_q  <= sat_nx;
		end
		if (state_q == ST_SCAN) begin
			prod_s1 <= PRW'(len_q) * PRW'(mx_q);
			prev_s1 <= (len_q <= seen_q) ? rd_q.total : '0;
			len_q   <= len_q + CW'(1);
			if (rd_q.value > mx_q) begin
				mx_q <= rd_q.value;
			end
		end
		if (finish) begin
			result.best_total <= best_nx;
			result.saturated  <= sat_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cfg_q        <= CFG_RESET;
			seen_q       <= '0;
			wptr_q       <= '0;
			valid_s1     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cfg_q <= cfg_data;
			end
			valid_s1 <= (state_q == ST_SCAN);
			if (result_valid && result_ready) begin
				result_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						seen_q  <= seen_c;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (len_q == lim_q) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						result_valid <= 1'b1;
						wptr_q       <= ptr_inc(wptr_q);
						if (32'(seen_q) < MAX_K) begin
							seen_q <= seen_q + CW'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// Testbench for segment_partition_max_sum_dp: drives value requests and segment-length writes,
// predicts each best partition total with its own window model and checks every result.
// Depends on spms_pkg and the block's top level only.
module testbench;
	import spms_pkg::*;

	localparam int WINDOW = MAX_K_DEF;
	localparam logic [63:0] TOTAL_CAP = (64'd1 << TOTAL_W) - 64'd1;
	localparam int CYCLE_LIMIT = 500000;
	localparam int LONG_STALL = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;

	segment_partition_max_sum_dp uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	item_t item_backlog[$];
	result_t predicted_totals[$];
	int queued_count = 0;
	int accepted_count = 0;
	int error_count = 0;
	int cycle_count = 0;
	int in_idle_pct = 0;
	int out_idle_pct = 0;
	int in_gap = 0;
	int out_gap = 0;
	int stall_count = 0;
	int stall_goal = 0;
	logic in_fire = 1'b0;

	logic [VALUE_W-1:0] value_hist[WINDOW];
	logic [TOTAL_W-1:0] total_hist[WINDOW];
	int unsigned seq_held = 0;
	logic [CFG_W-1:0] seg_limit = CFG_RESET;

	function automatic result_t best_partition(item_t it);
		int unsigned span;
		int unsigned reach;
		logic [63:0] peak;
		logic [63:0] best;
		logic [63:0] cand;
		logic [63:0] prior;
		logic clipped;
		result_t r;
		if (it.start_new)
			seq_held = 0;
		span = seg_limit;
		if (span < 1)
			span = 1;
		if (span > WINDOW)
			span = WINDOW;
		reach = seq_held + 1;
		if (reach > span)
			reach = span;
		peak = 64'(it.item_value);
		best = '0;
		clipped = 1'b0;
		for (int len = 1; len <= reach; len++) begin
			if (len > 1 && 64'(value_hist[len-2]) > peak)
				peak = 64'(value_hist[len-2]);
			prior = (len <= seq_held) ? 64'(total_hist[len-1]) : 64'd0;
			cand = prior + 64'(len) * peak;
			if (cand > TOTAL_CAP) begin
				cand = TOTAL_CAP;
				clipped = 1'b1;
			end
			if (cand > best)
				best = cand;
		end
		if (best < TOTAL_CAP)
			clipped = 1'b0;
		for (int i = WINDOW - 1; i > 0; i--) begin
			value_hist[i] = value_hist[i-1];
			total_hist[i] = total_hist[i-1];
		end
		value_hist[0] = it.item_value;
		total_hist[0] = best[TOTAL_W-1:0];
		if (seq_held < WINDOW)
			seq_held++;
		r.best_total = best[TOTAL_W-1:0];
		r.saturated = clipped;
		return r;
	endfunction

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		result_t want;
		in_fire <= arst_n && item_valid && item_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				seg_limit = cfg_data;
			if (result_valid && result_ready) begin
				if (predicted_totals.size() == 0) begin
					$error("unexpected result best_total %0d", result.best_total);
					error_count++;
				end else begin
					want = predicted_totals[0];
					predicted_totals.delete(0);
					if (result.best_total !== want.best_total) begin
						$error("best_total expected %0d actual %0d",
							want.best_total, result.best_total);
						error_count++;
					end
					if (result.saturated !== want.saturated) begin
						$error("saturated expected %0d actual %0d",
							want.saturated, result.saturated);
						error_count++;
					end
				end
			end
			if (item_valid && item_ready) begin
				predicted_totals = {predicted_totals, best_partition(item)};
				accepted_count++;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || in_fire) begin
			if (in_gap > 0) begin
				in_gap--;
				item_valid <= 1'b0;
			end else if (item_backlog.size() != 0 && $urandom_range(0, 99) < in_idle_pct) begin
				in_gap = $urandom_range(0, 4);
				item_valid <= 1'b0;
			end else if (item_backlog.size() != 0) begin
				item <= item_backlog[0];
				item_backlog.delete(0);
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else if (stall_count < stall_goal) begin
			stall_count++;
			result_ready <= 1'b0;
		end else if (out_gap > 0) begin
			out_gap--;
			result_ready <= 1'b0;
		end else if ($urandom_range(0, 99) < out_idle_pct) begin
			out_gap = $urandom_range(0, 4);
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	function automatic void queue_item(logic [VALUE_W-1:0] v, logic s);
		item_t it;
		it.item_value = v;
		it.start_new = s;
		item_backlog = {item_backlog, it};
		queued_count++;
	endfunction

	function automatic logic [VALUE_W-1:0] random_value();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return '1;
		if (pick == 1)
			return '0;
		if (pick < 4)
			return VALUE_W'($urandom_range(0, 15));
		return VALUE_W'($urandom_range(0, 65535));
	endfunction

	task automatic wait_idle();
		do @(negedge clk);
		while (accepted_count != queued_count || predicted_totals.size() != 0);
	endtask

	task automatic write_limit(input logic [CFG_W-1:0] v);
		wait_idle();
		@(negedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk);
		while (!(cfg_valid && cfg_ready));
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_phase(input logic [CFG_W-1:0] lim, input int count,
			input int in_pct, input int out_pct, input bit long_hold);
		write_limit(lim);
		in_idle_pct = in_pct;
		out_idle_pct = out_pct;
		queue_item(random_value(), 1'b1);
		for (int n = 1; n < count; n++)
			queue_item(random_value(), $urandom_range(0, 24) == 0);
		if (long_hold)
			stall_goal = stall_count + LONG_STALL;
	endtask

	initial begin
		logic [CFG_W-1:0] lims[12];
		lims = '{5'd31, 5'd17, 5'd2, 5'd1, 5'd0, 5'd16, 5'd5, 5'd9, 5'd3, 5'd0, 5'd16, 5'd0};
		lims[9] = CFG_W'($urandom_range(0, 31));
		lims[11] = CFG_W'($urandom_range(1, 16));
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default segment length; the first request carries no start flag.
		queue_item('1, 1'b0);
		queue_item('0, 1'b0);
		queue_item('1, 1'b0);
		queue_item(16'd1, 1'b1);
		queue_item('1, 1'b1);

		write_limit(5'd0);
		queue_item(16'd100, 1'b1);
		queue_item(16'd200, 1'b0);
		queue_item('1, 1'b0);

		// Segment length at the window depth: a run of requests with a fresh sequence started partway through.
		write_limit(5'd16);
		queue_item(16'd7, 1'b1);
		for (int i = 0; i < 15; i++)
			queue_item((i % 3 == 0) ? 16'hFFFF : VALUE_W'(i * 997), i == 11);

		for (int p = 0; p < 12; p++)
			random_phase(lims[p], 150, (p < 10) ? ((p % 3 == 2) ? 0 : 30) : 0,
				(p < 10) ? ((p % 4 == 3) ? 0 : 30) : 0, p == 4);

		wait_idle();
		repeat (2 * WINDOW + 8) @(posedge clk);
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
